>>> rtl/dahdsr_exp_envelope_defines.svh
// assertion macros for the dahdsr envelope rtl
// used by files that carry concurrent checks; needs clk and rst_n in scope
`ifndef DAHDSR_EXP_ENVELOPE_DEFINES_SVH
`define DAHDSR_EXP_ENVELOPE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DAE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dahdsr envelope check failed");

// next-cycle implication, disabled during reset
`define DAE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dahdsr envelope check failed");

`endif

>>> rtl/dahdsr_pkg.sv
// shared types, constants and helpers for the dahdsr envelope
// no dependencies
package dahdsr_pkg;

  localparam int LEVEL_W  = 24;
  localparam int LEN_W    = 24;
  localparam int CNT_W    = 25;
  localparam int FACTOR_W = 32;
  localparam int PHASE_W  = 3;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;
  localparam int unsigned DELAY_SAMPLES_DEF = 0;

  localparam logic [LEVEL_W-1:0] ENV_ONE   = 24'd8388608;
  localparam logic [LEVEL_W-1:0] ENV_FLOOR = 24'd8389;

  // register map, word index
  typedef enum logic [2:0] {
    REG_ATTACK_SAMPLES  = 3'd0,
    REG_HOLD_SAMPLES    = 3'd1,
    REG_DECAY_SAMPLES   = 3'd2,
    REG_RELEASE_SAMPLES = 3'd3,
    REG_SUSTAIN_LEVEL   = 3'd4,
    REG_ATTACK_FACTOR   = 3'd5,
    REG_DECAY_FACTOR    = 3'd6,
    REG_RELEASE_FACTOR  = 3'd7
  } reg_idx_t;

  // envelope phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_DELAY   = 7'b0000010,
    PH_ATTACK  = 7'b0000100,
    PH_HOLD    = 7'b0001000,
    PH_DECAY   = 7'b0010000,
    PH_SUSTAIN = 7'b0100000,
    PH_RELEASE = 7'b1000000
  } phase_t;

  // phase codes as seen on the result channel
  localparam logic [PHASE_W-1:0] PHC_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PHC_DELAY   = 3'd1;
  localparam logic [PHASE_W-1:0] PHC_ATTACK  = 3'd2;
  localparam logic [PHASE_W-1:0] PHC_HOLD    = 3'd3;
  localparam logic [PHASE_W-1:0] PHC_DECAY   = 3'd4;
  localparam logic [PHASE_W-1:0] PHC_SUSTAIN = 3'd5;
  localparam logic [PHASE_W-1:0] PHC_RELEASE = 3'd6;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] c;
    case (ph)
      PH_DELAY:   c = PHC_DELAY;
      PH_ATTACK:  c = PHC_ATTACK;
      PH_HOLD:    c = PHC_HOLD;
      PH_DECAY:   c = PHC_DECAY;
      PH_SUSTAIN: c = PHC_SUSTAIN;
      PH_RELEASE: c = PHC_RELEASE;
      default:    c = PHC_IDLE;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/dahdsr_in_if.sv
// input channel: one gate and trigger sample per item
// depends on nothing
interface dahdsr_in_if;
  logic valid;
  logic ready;
  logic gate_high;
  logic trigger_high;

  modport source (output valid, output gate_high, output trigger_high, input ready);
  modport sink   (input valid, input gate_high, input trigger_high, output ready);
endinterface

>>> rtl/dahdsr_out_if.sv
// result channel: envelope level and phase per item
// depends on dahdsr_pkg
interface dahdsr_out_if;
  import dahdsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] env_out;
  logic [PHASE_W-1:0] phase_out;

  modport source (output valid, output env_out, output phase_out, input ready);
  modport sink   (input valid, input env_out, input phase_out, output ready);
endinterface

>>> rtl/dahdsr_scale.sv
// level times factor, round half up, saturate at full scale
// depends on dahdsr_pkg
module dahdsr_scale (
  input  logic [dahdsr_pkg::LEVEL_W-1:0]  level_i,
  input  logic [dahdsr_pkg::FACTOR_W-1:0] factor_i,
  output logic [dahdsr_pkg::LEVEL_W-1:0]  scaled_o
);
  import dahdsr_pkg::*;

  localparam int PROD_W = LEVEL_W + FACTOR_W;
  localparam int SHR_W  = PROD_W + 1 - 23;

  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   rnd;
  logic [SHR_W-1:0]  shr;

  assign prod = level_i * factor_i;
  assign rnd  = {1'b0, prod} + (PROD_W+1)'(1 << 22);
  assign shr  = rnd[PROD_W:23];

  assign scaled_o = (shr > SHR_W'(ENV_ONE)) ? ENV_ONE : shr[LEVEL_W-1:0];
endmodule

>>> rtl/dahdsr_exp_envelope.sv
// top level of the dahdsr envelope generator with exponential segments
// depends on dahdsr_pkg, dahdsr_in_if, dahdsr_out_if, dahdsr_scale and the defines header
//
// One item in, one item out: each gate/trigger sample yields one Q1.23 level and the phase
// reached after that sample. Items can be taken one per cycle unless the output stalls, and
// pass the input register, then the result register. While a result waits, the input
// register can still take one more item, after which the input stalls. The cycle time is
// set by the attack/decay/release multiply (24 x 32 bits) with its rounding and saturation.
// Registers sit on a 32-bit APB-style port at byte address 4*index and must only be written
// while the block is idle. DELAY_SAMPLES fixes the delay length at build time.
`include "dahdsr_exp_envelope_defines.svh"

module dahdsr_exp_envelope #(
  parameter int unsigned DELAY_SAMPLES = dahdsr_pkg::DELAY_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dahdsr_in_if.sink                     in_chan,
  dahdsr_out_if.source                  out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dahdsr_pkg::APB_AW-1:0] paddr,
  input  logic [dahdsr_pkg::APB_DW-1:0] pwdata,
  output logic [dahdsr_pkg::APB_DW-1:0] prdata,
  output logic                          pready
);
  import dahdsr_pkg::*;

  // configuration registers
  logic [LEN_W-1:0]    attack_len_r, hold_len_r, decay_len_r, release_len_r;
  logic [LEVEL_W-1:0]  sustain_r, decay_fac_r, release_fac_r;
  logic [FACTOR_W-1:0] attack_fac_r;

  // envelope state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic               prev_gate_r, prev_trig_r;

  // input register
  logic s1_vld_r, s1_gate_r, s1_trig_r;

  // result register
  logic               out_vld_r;
  logic [LEVEL_W-1:0] out_env_r;
  logic [PHASE_W-1:0] out_phase_r;

  logic     advance, fire1, in_fire, cfg_wr;
  reg_idx_t cfg_idx;

  // combinational step
  logic               restart, falling;
  phase_t             ph_a, ph_b;
  logic [CNT_W-1:0]   cnt_b, cnt_inc;
  logic [LEVEL_W-1:0] lvl_b, sus, mul_lvl, scaled;
  logic [FACTOR_W-1:0] mul_fac;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r  <= '0;
      hold_len_r    <= '0;
      decay_len_r   <= '0;
      release_len_r <= '0;
      sustain_r     <= ENV_ONE;
      attack_fac_r  <= FACTOR_W'(ENV_ONE);
      decay_fac_r   <= ENV_ONE;
      release_fac_r <= ENV_ONE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATTACK_SAMPLES:  attack_len_r  <= pwdata[LEN_W-1:0];
        REG_HOLD_SAMPLES:    hold_len_r    <= pwdata[LEN_W-1:0];
        REG_DECAY_SAMPLES:   decay_len_r   <= pwdata[LEN_W-1:0];
        REG_RELEASE_SAMPLES: release_len_r <= pwdata[LEN_W-1:0];
        REG_SUSTAIN_LEVEL:   sustain_r     <= pwdata[LEVEL_W-1:0];
        REG_ATTACK_FACTOR:   attack_fac_r  <= pwdata[FACTOR_W-1:0];
        REG_DECAY_FACTOR:    decay_fac_r   <= pwdata[LEVEL_W-1:0];
        REG_RELEASE_FACTOR:  release_fac_r <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ATTACK_SAMPLES:  prdata = APB_DW'(attack_len_r);
      REG_HOLD_SAMPLES:    prdata = APB_DW'(hold_len_r);
      REG_DECAY_SAMPLES:   prdata = APB_DW'(decay_len_r);
      REG_RELEASE_SAMPLES: prdata = APB_DW'(release_len_r);
      REG_SUSTAIN_LEVEL:   prdata = APB_DW'(sustain_r);
      REG_ATTACK_FACTOR:   prdata = APB_DW'(attack_fac_r);
      REG_DECAY_FACTOR:    prdata = APB_DW'(decay_fac_r);
      REG_RELEASE_FACTOR:  prdata = APB_DW'(release_fac_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: input register feeds the result register, which stalls only
  // when it holds a result that has not been taken
  // ---------------------------------------------------------------------------
  assign advance       = !out_vld_r || out_chan.ready;
  assign fire1         = s1_vld_r && advance;
  assign in_chan.ready = !s1_vld_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_gate_r <= in_chan.gate_high;
      s1_trig_r <= in_chan.trigger_high;
    end
  end

  // ---------------------------------------------------------------------------
  // phase sequencing helpers: the phase that follows a finished segment,
  // skipping segments of zero length
  // ---------------------------------------------------------------------------
  function automatic phase_t after_decay(input logic gat, input logic rel_nz);
    phase_t p;
    if (gat) p = PH_SUSTAIN;
    else if (rel_nz) p = PH_RELEASE;
    else p = PH_IDLE;
    return p;
  endfunction

  function automatic phase_t after_hold(input logic gat, input logic dec_nz,
                                        input logic rel_nz);
    return dec_nz ? PH_DECAY : after_decay(gat, rel_nz);
  endfunction

  function automatic phase_t after_attack(input logic gat, input logic hld_nz,
                                          input logic dec_nz, input logic rel_nz);
    return hld_nz ? PH_HOLD : after_hold(gat, dec_nz, rel_nz);
  endfunction

  // sustain clamped into [floor, full scale]
  always_comb begin
    if (sustain_r < ENV_FLOOR) sus = ENV_FLOOR;
    else if (sustain_r > ENV_ONE) sus = ENV_ONE;
    else sus = sustain_r;
  end

  // edge handling: a rising edge restarts, then a falling gate takes over
  assign restart = (s1_trig_r && !prev_trig_r) || (s1_gate_r && !prev_gate_r);

  always_comb begin
    ph_a  = phase_r;
    cnt_b = cnt_r;
    lvl_b = lvl_r;
    if (restart) begin
      cnt_b = '0;
      if (DELAY_SAMPLES != 0) begin
        ph_a = PH_DELAY;
      end else if (attack_len_r != '0) begin
        ph_a = PH_ATTACK;
      end else begin
        ph_a  = after_attack(s1_gate_r, hold_len_r != '0, decay_len_r != '0,
                             release_len_r != '0);
        lvl_b = ENV_ONE;
      end
    end
  end

  assign falling = (ph_a != PH_IDLE) && (ph_a != PH_RELEASE) && prev_gate_r && !s1_gate_r;

  always_comb begin
    ph_b = ph_a;
    if (falling) begin
      ph_b = (release_len_r != '0) ? PH_RELEASE : PH_IDLE;
    end
  end

  // counter runs from the restarted or overridden value
  assign cnt_inc = (restart || falling) ? CNT_W'(1) : cnt_b + CNT_W'(1);

  // one shared multiplier; operands picked by the active segment
  always_comb begin
    case (ph_b)
      PH_ATTACK: begin
        mul_lvl = (lvl_b < ENV_FLOOR) ? ENV_FLOOR : lvl_b;
        mul_fac = attack_fac_r;
      end
      PH_DECAY: begin
        mul_lvl = lvl_b;
        mul_fac = FACTOR_W'(decay_fac_r);
      end
      default: begin
        mul_lvl = lvl_b;
        mul_fac = FACTOR_W'(release_fac_r);
      end
    endcase
  end

  dahdsr_scale u_scale (
    .level_i  (mul_lvl),
    .factor_i (mul_fac),
    .scaled_o (scaled)
  );

  // per-segment update
  always_comb begin
    phase_nxt = ph_b;
    cnt_nxt   = cnt_inc;
    lvl_nxt   = lvl_b;
    case (ph_b)
      PH_DELAY: begin
        if (cnt_inc > CNT_W'(DELAY_SAMPLES)) begin
          cnt_nxt = '0;
          if (attack_len_r != '0) begin
            phase_nxt = PH_ATTACK;
          end else begin
            phase_nxt = after_attack(s1_gate_r, hold_len_r != '0, decay_len_r != '0,
                                     release_len_r != '0);
            lvl_nxt   = ENV_ONE;
          end
        end
      end
      PH_ATTACK: begin
        if (cnt_inc > CNT_W'(attack_len_r)) begin
          phase_nxt = after_attack(s1_gate_r, hold_len_r != '0, decay_len_r != '0,
                                   release_len_r != '0);
          lvl_nxt   = ENV_ONE;
          cnt_nxt   = '0;
        end else begin
          lvl_nxt = scaled;
        end
      end
      PH_HOLD: begin
        if (cnt_inc > CNT_W'(hold_len_r)) begin
          phase_nxt = after_hold(s1_gate_r, decay_len_r != '0, release_len_r != '0);
          cnt_nxt   = '0;
        end
      end
      PH_DECAY: begin
        if (cnt_inc > CNT_W'(decay_len_r)) begin
          phase_nxt = after_decay(s1_gate_r, release_len_r != '0);
          lvl_nxt   = sus;
          cnt_nxt   = '0;
        end else begin
          lvl_nxt = scaled;
        end
      end
      PH_SUSTAIN: begin
        // counter is left alone while sustaining
        cnt_nxt = cnt_b;
        if (falling) cnt_nxt = '0;
        lvl_nxt = sus;
      end
      PH_RELEASE: begin
        if (cnt_inc > CNT_W'(release_len_r)) begin
          phase_nxt = PH_IDLE;
          lvl_nxt   = '0;
          cnt_nxt   = '0;
        end else begin
          lvl_nxt = scaled;
        end
      end
      default: begin
        // idle: counter keeps its restarted or overridden value
        phase_nxt = PH_IDLE;
        cnt_nxt   = (restart || falling) ? '0 : cnt_r;
        lvl_nxt   = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // state and result registers, updated once per item
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      lvl_r       <= '0;
      prev_gate_r <= 1'b0;
      prev_trig_r <= 1'b0;
    end else if (fire1) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      lvl_r       <= lvl_nxt;
      prev_gate_r <= s1_gate_r;
      prev_trig_r <= s1_trig_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      out_env_r   <= lvl_nxt;
      out_phase_r <= phase_code(phase_nxt);
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.env_out   = out_env_r;
  assign out_chan.phase_out = out_phase_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a waiting result stays put until it is taken
  `DAE_ASSERT_NEXT(a_out_hold, !advance, $stable({out_vld_r, out_env_r, out_phase_r}))
  // the level never rises above full scale
  `DAE_ASSERT_NOW(a_level_cap, fire1, lvl_nxt <= ENV_ONE)
  // a segment counter cannot run past the longest length plus one
  `DAE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(1 << LEN_W))
  // a held input item is not overwritten while the result side is stalled
  `DAE_ASSERT_NEXT(a_s1_hold, s1_vld_r && !advance, s1_vld_r)

endmodule

>>> tb/sv/dahdsr_envelope_checker.sv
// envelope checker: follows the register port, predicts each sample's level and phase
// and compares them with the result channel
// depends on dahdsr_pkg, dahdsr_in_if and dahdsr_out_if
module dahdsr_envelope_checker #(
  parameter int unsigned DELAY_LEN = dahdsr_pkg::DELAY_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dahdsr_in_if                          in_mon,
  dahdsr_out_if                         out_mon,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [dahdsr_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [dahdsr_pkg::APB_DW-1:0] cfg_pwdata,
  output int unsigned                   fail_count,
  output int unsigned                   pending
);
  import dahdsr_pkg::*;

  typedef struct {
    logic [LEVEL_W-1:0] env;
    logic [PHASE_W-1:0] phase;
  } envelope_point_t;

  // shadow of the register file
  logic [LEN_W-1:0]    atk_len, hold_len, dec_len, rel_len;
  logic [LEVEL_W-1:0]  sus_lvl, dec_fac, rel_fac;
  logic [FACTOR_W-1:0] atk_fac;

  // predicted envelope state
  logic [PHASE_W-1:0] st_phase;
  logic [CNT_W-1:0]   st_count;
  logic [LEVEL_W-1:0] st_level;
  logic               st_prev_gate, st_prev_trig;

  envelope_point_t expected_levels[$];
  int unsigned     fails;

  // level times factor, rounded half up, saturated at full scale
  function automatic logic [LEVEL_W-1:0] scaled(input logic [LEVEL_W-1:0] lvl,
                                                input logic [FACTOR_W-1:0] fac);
    logic [63:0] p;
    p = ({40'd0, lvl} * {32'd0, fac} + 64'd4194304) >> 23;
    return (p > {40'd0, ENV_ONE}) ? ENV_ONE : p[LEVEL_W-1:0];
  endfunction

  function automatic logic [PHASE_W-1:0] after_decay_phase(input logic gat);
    if (gat) return PHC_SUSTAIN;
    return (rel_len != 0) ? PHC_RELEASE : PHC_IDLE;
  endfunction

  function automatic logic [PHASE_W-1:0] after_hold_phase(input logic gat);
    return (dec_len != 0) ? PHC_DECAY : after_decay_phase(gat);
  endfunction

  function automatic logic [PHASE_W-1:0] after_attack_phase(input logic gat);
    return (hold_len != 0) ? PHC_HOLD : after_hold_phase(gat);
  endfunction

  function automatic envelope_point_t predict_envelope(input logic gat, input logic trg);
    logic [LEVEL_W-1:0] sus;
    logic [LEVEL_W-1:0] base;
    envelope_point_t    pt;
    sus = (sus_lvl < ENV_FLOOR) ? ENV_FLOOR : ((sus_lvl > ENV_ONE) ? ENV_ONE : sus_lvl);

    if ((trg && !st_prev_trig) || (gat && !st_prev_gate)) begin
      if (DELAY_LEN != 0) begin
        st_phase = PHC_DELAY;
      end else if (atk_len != 0) begin
        st_phase = PHC_ATTACK;
      end else begin
        st_phase = after_attack_phase(gat);
        st_level = ENV_ONE;
      end
      st_count = '0;
    end

    // a falling gate overrides a restart in the same sample
    if (st_phase != PHC_IDLE && st_phase != PHC_RELEASE && st_prev_gate && !gat) begin
      st_phase = (rel_len != 0) ? PHC_RELEASE : PHC_IDLE;
      st_count = '0;
    end

    case (st_phase)
      PHC_DELAY: begin
        st_count = st_count + 1'b1;
        if (st_count > DELAY_LEN) begin
          if (atk_len != 0) begin
            st_phase = PHC_ATTACK;
          end else begin
            st_phase = after_attack_phase(gat);
            st_level = ENV_ONE;
          end
          st_count = '0;
        end
      end
      PHC_ATTACK: begin
        st_count = st_count + 1'b1;
        if (st_count > atk_len) begin
          st_phase = after_attack_phase(gat);
          st_level = ENV_ONE;
          st_count = '0;
        end else begin
          base = (st_level < ENV_FLOOR) ? ENV_FLOOR : st_level;
          st_level = scaled(base, atk_fac);
        end
      end
      PHC_HOLD: begin
        st_count = st_count + 1'b1;
        if (st_count > hold_len) begin
          st_phase = after_hold_phase(gat);
          st_count = '0;
        end
      end
      PHC_DECAY: begin
        st_count = st_count + 1'b1;
        if (st_count > dec_len) begin
          st_phase = after_decay_phase(gat);
          st_level = sus;
          st_count = '0;
        end else begin
          st_level = scaled(st_level, {8'd0, dec_fac});
        end
      end
      PHC_SUSTAIN: st_level = sus;
      PHC_RELEASE: begin
        st_count = st_count + 1'b1;
        if (st_count > rel_len) begin
          st_phase = PHC_IDLE;
          st_level = '0;
          st_count = '0;
        end else begin
          st_level = scaled(st_level, {8'd0, rel_fac});
        end
      end
      default: begin
        st_phase = PHC_IDLE;
        st_level = '0;
      end
    endcase

    st_prev_gate = gat;
    st_prev_trig = trg;
    pt.env   = st_level;
    pt.phase = st_phase;
    return pt;
  endfunction

  always @(posedge clk) begin : watch
    envelope_point_t want;
    if (!rst_n) begin
      atk_len = '0; hold_len = '0; dec_len = '0; rel_len = '0;
      sus_lvl = ENV_ONE; atk_fac = {8'd0, ENV_ONE}; dec_fac = ENV_ONE; rel_fac = ENV_ONE;
      st_phase = PHC_IDLE; st_count = '0; st_level = '0;
      st_prev_gate = 1'b0; st_prev_trig = 1'b0;
      expected_levels.delete();
      fails = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_ATTACK_SAMPLES:  atk_len = cfg_pwdata[LEN_W-1:0];
          REG_HOLD_SAMPLES:    hold_len = cfg_pwdata[LEN_W-1:0];
          REG_DECAY_SAMPLES:   dec_len = cfg_pwdata[LEN_W-1:0];
          REG_RELEASE_SAMPLES: rel_len = cfg_pwdata[LEN_W-1:0];
          REG_SUSTAIN_LEVEL:   sus_lvl = cfg_pwdata[LEVEL_W-1:0];
          REG_ATTACK_FACTOR:   atk_fac = cfg_pwdata[FACTOR_W-1:0];
          REG_DECAY_FACTOR:    dec_fac = cfg_pwdata[LEVEL_W-1:0];
          REG_RELEASE_FACTOR:  rel_fac = cfg_pwdata[LEVEL_W-1:0];
          default: ;
        endcase
      end

      // results are matched before this edge's sample is queued
      if (out_mon.valid && out_mon.ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t unexpected item: env_out %0d phase_out %0d", $time,
                   out_mon.env_out, out_mon.phase_out);
          fails++;
        end else begin
          want = expected_levels.pop_front();
          if (out_mon.env_out !== want.env) begin
            $display("%0t env_out mismatch: expected %0d actual %0d", $time,
                     want.env, out_mon.env_out);
            fails++;
          end
          if (out_mon.phase_out !== want.phase) begin
            $display("%0t phase_out mismatch: expected %0d actual %0d", $time,
                     want.phase, out_mon.phase_out);
            fails++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready)
        expected_levels.push_back(predict_envelope(in_mon.gate_high, in_mon.trigger_high));
    end
    pending    <= expected_levels.size();
    fail_count <= fails;
  end

endmodule

>>> tb/sv/tb.sv
// top of the envelope testbench: clock, reset, register writes and gate/trigger stimulus
// depends on dahdsr_pkg, the two channel interfaces, dahdsr_exp_envelope and
// dahdsr_envelope_checker
module tb;
  import dahdsr_pkg::*;

  localparam int unsigned DELAY_LEN   = DELAY_SAMPLES_DEF;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned LONG_HOLD   = 250;      // receiver hold-off, in cycles
  localparam int unsigned RANDOM_RUNS = 6;
  localparam int unsigned RUN_ITEMS   = 312;

  // how the phase lengths are picked for a random run
  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_WIDE,
    LEN_LONGEST
  } len_mix_t;

  logic clk = 1'b0;
  logic rst_n;

  // register port
  logic              cfg_psel, cfg_penable, cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  dahdsr_in_if  in_if();
  dahdsr_out_if out_if();

  int unsigned fail_count, pending;
  int unsigned cycle_count = 0;

  // idling switch and long-stall request, both written only by the stimulus process
  bit idle_on;
  bit stall_kick;

  always #6 clk = ~clk;

  dahdsr_exp_envelope #(.DELAY_SAMPLES(DELAY_LEN)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready)
  );

  dahdsr_envelope_checker #(.DELAY_LEN(DELAY_LEN)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random back-pressure while idling is on, plus a long hold-off whenever the
  // stimulus toggles stall_kick; the hold-off is counted here and nowhere else
  initial begin : receiver
    bit          kick_seen;
    int unsigned hold_left;
    kick_seen = 1'b0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_kick != kick_seen) begin
        kick_seen = stall_kick;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 11);
      end
    end
  end

  // one register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // writes the whole register file, lengths first
  task automatic program_envelope(input logic [LEN_W-1:0] atk, input logic [LEN_W-1:0] hold,
                                  input logic [LEN_W-1:0] dec, input logic [LEN_W-1:0] rel,
                                  input logic [LEVEL_W-1:0] sus,
                                  input logic [FACTOR_W-1:0] afac,
                                  input logic [LEVEL_W-1:0] dfac,
                                  input logic [LEVEL_W-1:0] rfac);
    cfg_write(REG_ATTACK_SAMPLES,  {8'd0, atk});
    cfg_write(REG_HOLD_SAMPLES,    {8'd0, hold});
    cfg_write(REG_DECAY_SAMPLES,   {8'd0, dec});
    cfg_write(REG_RELEASE_SAMPLES, {8'd0, rel});
    cfg_write(REG_SUSTAIN_LEVEL,   {8'd0, sus});
    cfg_write(REG_ATTACK_FACTOR,   afac);
    cfg_write(REG_DECAY_FACTOR,    {8'd0, dfac});
    cfg_write(REG_RELEASE_FACTOR,  {8'd0, rfac});
  endtask

  // offers one gate/trigger item and returns at the edge where it is taken;
  // random idle cycles go in front of it while idling is on
  task automatic send_sample(input logic gat, input logic trg);
    while (idle_on && $urandom_range(99) < 11) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.gate_high    <= gat;
    in_if.trigger_high <= trg;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // stops offering and waits for every predicted item to come back
  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // picks a random register setting; lengths are mostly short so that the
  // envelope actually walks through its phases within a run
  task automatic random_settings(input len_mix_t mix);
    logic [LEN_W-1:0]    len[4];
    logic [FACTOR_W-1:0] afac;
    logic [LEVEL_W-1:0]  sus, dfac, rfac;
    for (int i = 0; i < 4; i++) begin
      case (mix)
        LEN_LONGEST: len[i] = 24'hFFFFFF;
        LEN_WIDE:    len[i] = 24'($urandom());
        default:     len[i] = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(1, 8));
      endcase
    end
    case ($urandom_range(3))
      0:       afac = $urandom();
      1:       afac = 32'd8388608 + $urandom_range(0, 2000000);   // gentle rise
      2:       afac = 32'd0;
      default: afac = 32'hFFFFFFFF;
    endcase
    // sustain sometimes below the floor
    sus  = ($urandom_range(3) == 0) ? 24'($urandom_range(0, 8388)) :
                                      24'($urandom_range(0, 8388608));
    dfac = $urandom_range(1) ? 24'($urandom_range(7000000, 8388608)) :
                               24'($urandom_range(0, 8388608));
    rfac = $urandom_range(1) ? 24'($urandom_range(7000000, 8388608)) :
                               24'($urandom_range(0, 8388608));
    program_envelope(len[0], len[1], len[2], len[3], sus, afac, dfac, rfac);
  endtask

  // mostly well-formed notes: gate held open, then closed, with the odd trigger
  // pulse; about one run in five is plain noise on both bits
  task automatic random_samples(input int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    logic        gat;
    bit          noisy;
    sent = 0;
    gat  = 1'b0;
    while (sent < count) begin
      noisy   = ($urandom_range(99) < 20);
      gat     = ~gat;
      run_len = gat ? $urandom_range(1, 40) : $urandom_range(1, 25);
      for (int k = 0; k < run_len && sent < count; k++) begin
        if (noisy)
          send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_sample(gat, $urandom_range(99) < 6);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    len_mix_t mix;
    // every input known from time zero
    rst_n              <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    in_if.valid        <= 1'b0;
    in_if.gate_high    <= 1'b0;
    in_if.trigger_high <= 1'b0;
    idle_on            <= 1'b1;
    stall_kick         <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, first setting: attack from silence with a factor that saturates,
    // decay by half, sustain under the floor, release straight to zero
    program_envelope(24'd3, 24'd1, 24'd2, 24'd2, 24'd0, 32'hFFFFFFFF, 24'd4194304, 24'd0);
    send_sample(1'b0, 1'b0);
    repeat (9) send_sample(1'b1, 1'b0);     // attack, hold, decay, sustain
    repeat (4) send_sample(1'b0, 1'b0);     // release then idle
    send_sample(1'b0, 1'b1);                // trigger with the gate closed
    repeat (3) send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);                // restart and falling gate together
    send_sample(1'b0, 1'b0);
    drain;

    // directed, second setting: every phase skipped, full-scale sustain
    program_envelope(24'd0, 24'd0, 24'd0, 24'd0, 24'd8388608, 32'hFFFFFFFF,
                     24'd8388608, 24'd8388608);
    send_sample(1'b1, 1'b0);                // attack skipped, level jumps to full
    send_sample(1'b0, 1'b0);                // release of zero length goes idle
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    drain;

    // random runs, each with its own register setting
    for (int run = 0; run < RANDOM_RUNS; run++) begin
      case (run)
        2:       mix = LEN_LONGEST;
        4:       mix = LEN_WIDE;
        default: mix = LEN_SHORT;
      endcase
      random_settings(mix);
      idle_on <= (run != 3);                // run 3 is the stretch with no idling
      if (run == 1 || run == 5)
        stall_kick <= ~stall_kick;          // long receiver hold-off, input backs up
      random_samples(RUN_ITEMS);
      drain;
    end

    // let the pipeline settle before the verdict
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
